// ===== hdl/i2cram_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cram_pkg
// Types and constants shared by the I2C register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_DEVICE_ADDRESS  = 2'd0;
   localparam logic [1:0] CSR_TICKS_PER_PHASE = 2'd1;
   localparam logic [1:0] CSR_ACK_WAIT_LIMIT  = 2'd2;

   // Reset values of the configuration registers
   localparam logic [6:0]  DEVICE_ADDRESS_RESET  = 7'd81;
   localparam logic [15:0] TICKS_PER_PHASE_RESET = 16'd24;
   localparam logic [15:0] ACK_WAIT_LIMIT_RESET  = 16'd2000;

   // Bits per transferred byte
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // Byte positions within a transaction
   localparam logic [1:0] BYTE_DEVICE   = 2'd0;
   localparam logic [1:0] BYTE_REGISTER = 2'd1;
   localparam logic [1:0] BYTE_DATA     = 2'd2;

   // Operation codes
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Bus sequencer states, one-hot
   typedef enum logic [15:0] {
      S_IDLE     = 16'b0000_0000_0000_0001,
      S_ST_A     = 16'b0000_0000_0000_0010,
      S_ST_B     = 16'b0000_0000_0000_0100,
      S_ST_C     = 16'b0000_0000_0000_1000,
      S_ST_D     = 16'b0000_0000_0001_0000,
      S_TX_LOW   = 16'b0000_0000_0010_0000,
      S_TX_HIGH  = 16'b0000_0000_0100_0000,
      S_ACK_LOW  = 16'b0000_0000_1000_0000,
      S_ACK_HIGH = 16'b0000_0001_0000_0000,
      S_RX_LOW   = 16'b0000_0010_0000_0000,
      S_RX_HIGH  = 16'b0000_0100_0000_0000,
      S_MN_LOW   = 16'b0000_1000_0000_0000,
      S_MN_HIGH  = 16'b0001_0000_0000_0000,
      S_SP_A     = 16'b0010_0000_0000_0000,
      S_SP_B     = 16'b0100_0000_0000_0000,
      S_SP_C     = 16'b1000_0000_0000_0000
   } seq_state_type;

   // One tick as it travels from the front queue to the sequencer
   typedef struct packed {
      logic       start_cmd;
      logic       func;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic       sda_in;
   } tick_item_type;

   // Configuration write as seen by the sequencer
   typedef struct packed {
      logic        wr;
      logic [1:0]  index;
      logic [15:0] data;
   } csr_write_type;

endpackage

// ===== hdl/i2c_register_access_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_master
// I2C master for single-byte register reads and writes, one bus tick per item.
// ----------------------------------------------------------------------------
// Each req item is one time tick of the bus: it carries the command strobe,
// operation, register address, write data and the sampled SDA level, and each
// tick gives exactly one rsp item with the SCL/SDA drive for that tick, the
// busy and done flags, the last read byte and the sticky NACK flag. The block
// takes one item per clock and, while rsp_ready is high, answers one per
// clock: a short queue at the front holds ticks while the sequencer steps, and
// the sequencer's result register lets the next tick be taken in the same
// cycle that a waiting result is taken. Configuration (device address, ticks
// per phase, acknowledge wait limit) is to be written over the csr_ port only
// while the block is idle; the block itself does not enforce this. csr_ready
// is always high and writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module i2c_register_access_master
   import i2cram_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // tick items in
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_start_cmd,
   input  logic        req_func,
   input  logic [7:0]  req_reg_addr,
   input  logic [7:0]  req_write_data,
   input  logic        req_sda_in,
   // result items out
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_pull_low,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_nack_seen,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   tick_item_type in_item, q_item;
   csr_write_type csr_wr;
   logic          q_valid, q_pop;

   // Pack the tick fields for the queue
   assign in_item.start_cmd  = req_start_cmd;
   assign in_item.func       = req_func;
   assign in_item.reg_addr   = req_reg_addr;
   assign in_item.write_data = req_write_data;
   assign in_item.sda_in     = req_sda_in;

   // Configuration is always taken at once
   assign csr_ready    = 1'b1;
   assign csr_wr.wr    = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   // Front: hold incoming ticks until the sequencer takes them
   i2cram_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_item   (q_item)
   );

   // Back: advance the bus sequence by one tick per queued item
   i2cram_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .csr_wr           (csr_wr),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_item           (q_item),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_scl_level    (rsp_scl_level),
      .out_sda_pull_low (rsp_sda_pull_low),
      .out_busy_res     (rsp_busy_res),
      .out_done_res     (rsp_done_res),
      .out_read_byte    (rsp_read_byte),
      .out_nack_seen    (rsp_nack_seen)
   );

endmodule

// ===== hdl/i2cram_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cram_front
// Input side: accepts tick items into a short queue for the sequencer.
// ----------------------------------------------------------------------------
module i2cram_front
   import i2cram_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  tick_item_type in_item,
   output logic          q_valid,
   input  logic          q_pop,
   output tick_item_type q_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   tick_item_type    entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready = (count_ff != FULL_CNT);
   assign q_valid  = (count_ff != '0);
   assign q_item   = entry_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== hdl/i2cram_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cram_seq
// Back side: bus sequencer stepped once per tick, with result register.
// ----------------------------------------------------------------------------
module i2cram_seq
   import i2cram_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr_wr,
   input  logic          q_valid,
   output logic          q_pop,
   input  tick_item_type q_item,
   output logic          out_valid,
   input  logic          out_ready,
   output logic          out_scl_level,
   output logic          out_sda_pull_low,
   output logic          out_busy_res,
   output logic          out_done_res,
   output logic [7:0]    out_read_byte,
   output logic          out_nack_seen
);

   // Configuration
   logic [6:0]  dev_addr_ff;
   logic [15:0] tpp_ff;
   logic [15:0] ack_limit_ff;

   // Sequencer state
   seq_state_type state_ff, state_in, cur;
   logic [3:0]  bit_ff, bit_in, bit_next;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] div_ff, div_in;
   logic [15:0] ack_ff, ack_in;
   logic        l_func_ff, l_func_in;
   logic [7:0]  l_reg_ff, l_reg_in;
   logic [7:0]  l_data_ff, l_data_in;
   logic [7:0]  result_ff, result_in;
   logic        nack_ff, nack_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;

   // Result register
   logic        valid_ff;
   logic        scl_ff, pull_ff, busy_ff, done_ff;
   logic        scl, pull, busy, done;

   logic        step;

   assign step  = q_valid && (!valid_ff || out_ready);
   assign q_pop = step;

   always_comb begin
      state_in    = state_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      div_in      = div_ff;
      ack_in      = ack_ff;
      l_func_in   = l_func_ff;
      l_reg_in    = l_reg_ff;
      l_data_in   = l_data_ff;
      result_in   = result_ff;
      nack_in     = nack_ff;
      byte_idx_in = byte_idx_ff;
      bit_next    = bit_ff + 4'd1;
      done        = 1'b0;

      // Latch a command when idle; this tick is already the first START tick
      if (state_ff == S_IDLE && q_item.start_cmd) begin
         l_func_in   = q_item.func;
         l_reg_in    = q_item.reg_addr;
         l_data_in   = q_item.write_data;
         nack_in     = 1'b0;
         byte_idx_in = BYTE_DEVICE;
         bit_in      = '0;
         ack_in      = '0;
         state_in    = S_ST_A;
         div_in      = '0;
      end
      cur = state_in;

      unique case (cur)
         S_ST_A:                         begin scl = 1'b0; pull = 1'b0; end
         S_ST_B:                         begin scl = 1'b1; pull = 1'b0; end
         S_ST_C:                         begin scl = 1'b1; pull = 1'b1; end
         S_ST_D:                         begin scl = 1'b0; pull = 1'b1; end
         S_TX_LOW:                       begin scl = 1'b0; pull = ~shift_in[7]; end
         S_TX_HIGH:                      begin scl = 1'b1; pull = ~shift_in[7]; end
         S_ACK_LOW, S_RX_LOW, S_MN_LOW:  begin scl = 1'b0; pull = 1'b0; end
         S_ACK_HIGH, S_RX_HIGH, S_MN_HIGH: begin scl = 1'b1; pull = 1'b0; end
         S_SP_A:                         begin scl = 1'b0; pull = 1'b1; end
         S_SP_B:                         begin scl = 1'b1; pull = 1'b1; end
         S_SP_C:                         begin scl = 1'b1; pull = 1'b0; end
         default:                        begin scl = 1'b1; pull = 1'b0; end
      endcase
      busy = (cur != S_IDLE);
      bit_next = bit_in + 4'd1;

      if (busy) begin
         if (({1'b0, div_in} + 17'd1) < {1'b0, tpp_ff}) begin
            div_in = div_in + 16'd1;
         end else begin
            div_in = '0;
            unique case (cur)
               S_ST_A: state_in = S_ST_B;
               S_ST_B: state_in = S_ST_C;
               S_ST_C: state_in = S_ST_D;
               S_ST_D: begin
                  shift_in = {dev_addr_ff, (byte_idx_in == BYTE_DATA)};
                  bit_in   = '0;
                  state_in = S_TX_LOW;
               end
               S_TX_LOW: state_in = S_TX_HIGH;
               S_TX_HIGH: begin
                  shift_in = {shift_in[6:0], 1'b0};
                  if (bit_next >= BITS_PER_BYTE) begin
                     bit_in   = '0;
                     ack_in   = '0;
                     state_in = S_ACK_LOW;
                  end else begin
                     bit_in   = bit_next;
                     state_in = S_TX_LOW;
                  end
               end
               S_ACK_LOW: state_in = S_ACK_HIGH;
               S_ACK_HIGH: begin
                  if (q_item.sda_in && ack_in < ack_limit_ff) begin
                     // keep waiting: hold the divider at the end of the phase
                     ack_in = ack_in + 16'd1;
                     div_in = div_ff;
                  end else begin
                     if (q_item.sda_in) begin
                        nack_in = 1'b1;
                     end
                     priority if (byte_idx_in == BYTE_DEVICE) begin
                        byte_idx_in = BYTE_REGISTER;
                        shift_in    = l_reg_in;
                        bit_in      = '0;
                        state_in    = S_TX_LOW;
                     end else if (byte_idx_in == BYTE_REGISTER) begin
                        byte_idx_in = BYTE_DATA;
                        if (l_func_in == FUNC_WRITE) begin
                           shift_in = l_data_in;
                           bit_in   = '0;
                           state_in = S_TX_LOW;
                        end else begin
                           state_in = S_ST_A;
                        end
                     end else begin
                        if (l_func_in == FUNC_WRITE) begin
                           state_in = S_SP_A;
                        end else begin
                           bit_in   = '0;
                           shift_in = '0;
                           state_in = S_RX_LOW;
                        end
                     end
                  end
               end
               S_RX_LOW: state_in = S_RX_HIGH;
               S_RX_HIGH: begin
                  shift_in = {shift_in[6:0], q_item.sda_in};
                  if (bit_next >= BITS_PER_BYTE) begin
                     bit_in    = '0;
                     result_in = shift_in;
                     state_in  = S_MN_LOW;
                  end else begin
                     bit_in   = bit_next;
                     state_in = S_RX_LOW;
                  end
               end
               S_MN_LOW:  state_in = S_MN_HIGH;
               S_MN_HIGH: state_in = S_SP_A;
               S_SP_A:    state_in = S_SP_B;
               S_SP_B:    state_in = S_SP_C;
               S_SP_C: begin
                  done     = 1'b1;
                  state_in = S_IDLE;
               end
               default: state_in = S_IDLE;
            endcase
         end
      end else begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= DEVICE_ADDRESS_RESET;
         tpp_ff       <= TICKS_PER_PHASE_RESET;
         ack_limit_ff <= ACK_WAIT_LIMIT_RESET;
      end else if (csr_wr.wr) begin
         unique case (csr_wr.index)
            CSR_DEVICE_ADDRESS:  dev_addr_ff  <= csr_wr.data[6:0];
            CSR_TICKS_PER_PHASE: tpp_ff       <= csr_wr.data;
            CSR_ACK_WAIT_LIMIT:  ack_limit_ff <= csr_wr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         bit_ff      <= '0;
         shift_ff    <= '0;
         div_ff      <= '0;
         ack_ff      <= '0;
         l_func_ff   <= 1'b0;
         l_reg_ff    <= '0;
         l_data_ff   <= '0;
         result_ff   <= '0;
         nack_ff     <= 1'b0;
         byte_idx_ff <= BYTE_DEVICE;
         valid_ff    <= 1'b0;
      end else begin
         if (step) begin
            state_ff    <= state_in;
            bit_ff      <= bit_in;
            shift_ff    <= shift_in;
            div_ff      <= div_in;
            ack_ff      <= ack_in;
            l_func_ff   <= l_func_in;
            l_reg_ff    <= l_reg_in;
            l_data_ff   <= l_data_in;
            result_ff   <= result_in;
            nack_ff     <= nack_in;
            byte_idx_ff <= byte_idx_in;
         end
         if (step) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         scl_ff  <= scl;
         pull_ff <= pull;
         busy_ff <= busy;
         done_ff <= done;
      end
   end

   assign out_valid        = valid_ff;
   assign out_scl_level    = scl_ff;
   assign out_sda_pull_low = pull_ff;
   assign out_busy_res     = busy_ff;
   assign out_done_res     = done_ff;
   assign out_read_byte    = result_ff;
   assign out_nack_seen    = nack_ff;

endmodule

// ===== hdl/i2cram_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cram_checker
// Port-level checks on the I2C register access master, bound to the top.
// ----------------------------------------------------------------------------
module i2cram_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_scl_level,
   input logic        rsp_sda_pull_low,
   input logic        rsp_busy_res,
   input logic        rsp_done_res,
   input logic [7:0]  rsp_read_byte,
   input logic        rsp_nack_seen
);

   // A stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte)
         && $stable(rsp_busy_res) && $stable(rsp_done_res)
         && $stable(rsp_scl_level) && $stable(rsp_sda_pull_low)
         && $stable(rsp_nack_seen))
      else $error("stalled result changed");

   // Stop completes only inside a transaction, with both lines released
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res && rsp_scl_level && !rsp_sda_pull_low)
      else $error("done outside a released stop phase");

   // An idle bus is fully released
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_scl_level && !rsp_sda_pull_low && !rsp_done_res)
      else $error("idle tick drives the bus");

   // Nothing comes out straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present after reset");

endmodule

bind i2c_register_access_master i2cram_checker u_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C register access master.
// ----------------------------------------------------------------------------
// Feeds bus ticks into the block one item at a time and mirrors the bus
// sequencer in a small class: every accepted tick advances the mirror, which
// queues the SCL/SDA levels and status flags that tick must produce. Each
// result item is checked field by field against the oldest queued entry.
// A short directed pass covers the register extremes, both operations, NACK
// by timeout, acknowledge at the last allowed tick and commands arriving
// while busy; random sessions then run well-formed transfers with random
// content under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top
   import i2cram_pkg::*;
();

   // Unused register index: writes there must be dropped
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // Random sessions and their busy-tick budget
   localparam int SESSIONS      = 4;
   localparam int SESSION_TICKS = 60;

   // Long receiver hold-off, in clock cycles
   localparam int HOLD_CYCLES = 300;

   // Cycles to let pass once nothing is pending
   localparam int SETTLE_CYCLES = 8;

   // Width of one packed tick item
   localparam int TICK_BITS = $bits(tick_item_type);

   // How the bench answers acknowledge bits
   typedef enum int {
      RESP_PROMPT,  // SDA low straight away
      RESP_LATE,    // SDA high until late_n extra samples were waited, then low
      RESP_FLAKY,   // SDA low at random
      RESP_ABSENT   // SDA never pulled low
   } responder_type;

   // Levels and flags one tick produces
   typedef struct packed {
      logic       scl;
      logic       pull;
      logic       busy;
      logic       done;
      logic [7:0] rd;
      logic       nack;
   } bus_levels_type;

   // -------------------------------------------------------------------------
   // Mirror of the bus sequencer plus the queue of levels still to arrive
   // -------------------------------------------------------------------------
   class i2c_bus_mirror;
      logic [6:0]     dev_addr;
      logic [15:0]    phase_ticks;
      logic [15:0]    ack_limit;
      seq_state_type  seq;
      logic [3:0]     bit_cnt;
      logic [7:0]     shifter;
      logic [15:0]    phase_cnt;
      logic [15:0]    ack_cnt;
      logic           cmd_func;
      logic [7:0]     cmd_reg;
      logic [7:0]     cmd_data;
      logic [7:0]     rd_byte;
      logic           nack;
      logic [1:0]     byte_pos;
      bus_levels_type pending_levels[$];
      int             result_count;
      int             mismatch_count;

      function new();
         dev_addr       = DEVICE_ADDRESS_RESET;
         phase_ticks    = TICKS_PER_PHASE_RESET;
         ack_limit      = ACK_WAIT_LIMIT_RESET;
         seq            = S_IDLE;
         bit_cnt        = '0;
         shifter        = '0;
         phase_cnt      = '0;
         ack_cnt        = '0;
         cmd_func       = FUNC_READ;
         cmd_reg        = '0;
         cmd_data       = '0;
         rd_byte        = '0;
         nack           = 1'b0;
         byte_pos       = BYTE_DEVICE;
         result_count   = 0;
         mismatch_count = 0;
      endfunction

      function void write_register(logic [1:0] index, logic [15:0] value);
         case (index)
            CSR_DEVICE_ADDRESS:  dev_addr    = value[6:0];
            CSR_TICKS_PER_PHASE: phase_ticks = value;
            CSR_ACK_WAIT_LIMIT:  ack_limit   = value;
            default: ;
         endcase
      endfunction

      function void enter(seq_state_type s);
         seq       = s;
         phase_cnt = '0;
      endfunction

      function void load_byte(logic [7:0] value);
         shifter = value;
         bit_cnt = '0;
         enter(S_TX_LOW);
      endfunction

      function void after_ack();
         if (byte_pos == BYTE_DEVICE) begin
            byte_pos = BYTE_REGISTER;
            load_byte(cmd_reg);
         end else if (byte_pos == BYTE_REGISTER) begin
            byte_pos = BYTE_DATA;
            if (cmd_func == FUNC_WRITE) load_byte(cmd_data);
            else enter(S_ST_A);
         end else if (cmd_func == FUNC_WRITE) begin
            enter(S_SP_A);
         end else begin
            bit_cnt = '0;
            shifter = '0;
            enter(S_RX_LOW);
         end
      endfunction

      // Advance by one accepted tick and queue the levels it must give
      function void note_tick(tick_item_type t);
         bus_levels_type lv;
         seq_state_type  s;
         if (seq == S_IDLE && t.start_cmd) begin
            cmd_func = t.func;
            cmd_reg  = t.reg_addr;
            cmd_data = t.write_data;
            nack     = 1'b0;
            byte_pos = BYTE_DEVICE;
            bit_cnt  = '0;
            ack_cnt  = '0;
            enter(S_ST_A);
         end
         s       = seq;
         lv.scl  = 1'b1;
         lv.pull = 1'b0;
         lv.done = 1'b0;
         case (s)
            S_ST_A:    lv.scl = 1'b0;
            S_ST_C:    lv.pull = 1'b1;
            S_ST_D: begin
               lv.scl  = 1'b0;
               lv.pull = 1'b1;
            end
            S_TX_LOW: begin
               lv.scl  = 1'b0;
               lv.pull = ~shifter[7];
            end
            S_TX_HIGH: lv.pull = ~shifter[7];
            S_ACK_LOW, S_RX_LOW, S_MN_LOW: lv.scl = 1'b0;
            S_SP_A: begin
               lv.scl  = 1'b0;
               lv.pull = 1'b1;
            end
            S_SP_B:    lv.pull = 1'b1;
            default: ;
         endcase
         lv.busy = (s != S_IDLE);
         if (lv.busy) begin
            // a zero phase length behaves as one tick per phase
            if (int'(phase_cnt) + 1 < int'(phase_ticks)) begin
               phase_cnt = phase_cnt + 16'd1;
            end else begin
               case (s)
                  S_ST_A: enter(S_ST_B);
                  S_ST_B: enter(S_ST_C);
                  S_ST_C: enter(S_ST_D);
                  S_ST_D: load_byte({dev_addr, byte_pos == BYTE_DATA});
                  S_TX_LOW: enter(S_TX_HIGH);
                  S_TX_HIGH: begin
                     shifter = {shifter[6:0], 1'b0};
                     bit_cnt = bit_cnt + 4'd1;
                     if (bit_cnt >= BITS_PER_BYTE) begin
                        bit_cnt = '0;
                        ack_cnt = '0;
                        enter(S_ACK_LOW);
                     end else begin
                        enter(S_TX_LOW);
                     end
                  end
                  S_ACK_LOW: enter(S_ACK_HIGH);
                  S_ACK_HIGH: begin
                     // keep sampling while SDA stays high and the wait allows
                     if (t.sda_in && ack_cnt < ack_limit) begin
                        ack_cnt = ack_cnt + 16'd1;
                     end else begin
                        if (t.sda_in) nack = 1'b1;
                        after_ack();
                     end
                  end
                  S_RX_LOW: enter(S_RX_HIGH);
                  S_RX_HIGH: begin
                     shifter = {shifter[6:0], t.sda_in};
                     bit_cnt = bit_cnt + 4'd1;
                     if (bit_cnt >= BITS_PER_BYTE) begin
                        bit_cnt = '0;
                        rd_byte = shifter;
                        enter(S_MN_LOW);
                     end else begin
                        enter(S_RX_LOW);
                     end
                  end
                  S_MN_LOW:  enter(S_MN_HIGH);
                  S_MN_HIGH: enter(S_SP_A);
                  S_SP_A:    enter(S_SP_B);
                  S_SP_B:    enter(S_SP_C);
                  S_SP_C: begin
                     lv.done = 1'b1;
                     enter(S_IDLE);
                  end
                  default: enter(S_IDLE);
               endcase
            end
         end
         lv.rd   = rd_byte;
         lv.nack = nack;
         pending_levels.push_back(lv);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result %0d %s: expected %0h, got %0h",
                        result_count, name, want, got);
         end
      endfunction

      function void check_result(bus_levels_type got);
         bus_levels_type want;
         if (pending_levels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result %0d arrived with no tick pending", result_count);
         end else begin
            want = pending_levels.pop_front();
            compare_field("scl_level",    8'(want.scl),  8'(got.scl));
            compare_field("sda_pull_low", 8'(want.pull), 8'(got.pull));
            compare_field("busy_res",     8'(want.busy), 8'(got.busy));
            compare_field("done_res",     8'(want.done), 8'(got.done));
            compare_field("read_byte",    want.rd,       got.rd);
            compare_field("nack_seen",    8'(want.nack), 8'(got.nack));
         end
         result_count++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and the block
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_start_cmd;
   logic        req_func;
   logic [7:0]  req_reg_addr;
   logic [7:0]  req_write_data;
   logic        req_sda_in;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_pull_low;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_byte;
   logic        rsp_nack_seen;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   i2c_bus_mirror mirror;

   // Idling pattern, in percent of cycles
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // Long hold-off of the receiver
   bit   hold_armed  = 1'b0;
   logic hold_active = 1'b0;

   i2c_register_access_master u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_cmd    (req_start_cmd),
      .req_func         (req_func),
      .req_reg_addr     (req_reg_addr),
      .req_write_data   (req_write_data),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_scl_level    (rsp_scl_level),
      .rsp_sda_pull_low (rsp_sda_pull_low),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_nack_seen    (rsp_nack_seen),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // -------------------------------------------------------------------------
   // Result side: check every accepted item, then decide next cycle's ready.
   // Outputs are read at the edge, before the block's own updates land.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      bus_levels_type seen;
      if (rsp_valid && rsp_ready) begin
         seen.scl  = rsp_scl_level;
         seen.pull = rsp_sda_pull_low;
         seen.busy = rsp_busy_res;
         seen.done = rsp_done_res;
         seen.rd   = rsp_read_byte;
         seen.nack = rsp_nack_seen;
         mirror.check_result(seen);
      end
      if (reset || hold_active) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Hold the receiver off for a long stretch once armed; the sender keeps
   // offering, so the front queue fills and req_ready must drop
   initial begin
      wait (hold_armed);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // End the run if it hangs; allows many times the slowest correct run
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driving tasks
   // -------------------------------------------------------------------------

   // Offer one tick item, idling first at random, and hold it until taken
   task automatic send_tick(input tick_item_type t);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_start_cmd  <= t.start_cmd;
      req_func       <= t.func;
      req_reg_addr   <= t.reg_addr;
      req_write_data <= t.write_data;
      req_sda_in     <= t.sda_in;
      do @(posedge clock); while (!req_ready);
      mirror.note_tick(t);
   endtask

   // Drop valid and wait until every queued result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (mirror.pending_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; the caller drops csr_valid after the last write
   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      mirror.write_register(index, value);
   endtask

   // Reconfigure an idle block; junk in the upper address bits and a write
   // to the unused index must both be ignored
   task automatic configure(input logic [6:0] addr, input logic [15:0] ticks,
                            input logic [15:0] limit);
      wait_drained();
      write_csr(CSR_DEVICE_ADDRESS, {9'($urandom_range(511)), addr});
      write_csr(CSR_TICKS_PER_PHASE, ticks);
      write_csr(CSR_ACK_WAIT_LIMIT, limit);
      write_csr(CSR_UNUSED, 16'($urandom_range(65535)));
      csr_valid <= 1'b0;
   endtask

   // Ticks with no command: the block must stay idle
   task automatic idle_noise(input int count);
      tick_item_type t;
      repeat (count) begin
         t            = tick_item_type'(TICK_BITS'($urandom()));
         t.start_cmd  = 1'b0;
         send_tick(t);
      end
   endtask

   // SDA seen by the master on the next tick, from the mirror's phase
   function automatic logic bus_sda(input responder_type style, input int late_n,
                                    input logic [7:0] rd_val);
      if (mirror.seq == S_ACK_HIGH) begin
         case (style)
            RESP_PROMPT: return 1'b0;
            RESP_LATE:   return (int'(mirror.ack_cnt) < late_n);
            RESP_FLAKY:  return ($urandom_range(9) < 7);
            default:     return 1'b1;
         endcase
      end
      if (mirror.seq == S_RX_HIGH) return rd_val[4'd7 - mirror.bit_cnt];
      return 1'($urandom_range(1));
   endfunction

   // One whole transfer from idle to the end of STOP; returns ticks used
   task automatic run_transfer(input logic func, input logic [7:0] reg_addr,
                               input logic [7:0] wr_data, input responder_type style,
                               input int late_n, input logic [7:0] rd_val,
                               input int busy_start_pct, output int ticks);
      tick_item_type t;
      t.start_cmd  = 1'b1;
      t.func       = func;
      t.reg_addr   = reg_addr;
      t.write_data = wr_data;
      t.sda_in     = 1'($urandom_range(1));
      send_tick(t);
      ticks = 1;
      while (mirror.seq != S_IDLE) begin
         // commands offered while busy carry random fields and are ignored
         t            = tick_item_type'(TICK_BITS'($urandom()));
         t.start_cmd  = ($urandom_range(99) < busy_start_pct);
         t.sda_in     = bus_sda(style, late_n, rd_val);
         send_tick(t);
         ticks++;
      end
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Absent targets only where the wait limit keeps the timeout short
   function automatic responder_type pick_responder();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return RESP_PROMPT;
      if (roll < 72) return RESP_LATE;
      if (roll < 86 || mirror.ack_limit > 16'd40) return RESP_FLAKY;
      return RESP_ABSENT;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int         spent;
      int         budget;
      logic [6:0] addr;
      logic [15:0] ticks;
      logic [15:0] limit;
      mirror = new();
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_start_cmd  <= 1'b0;
      req_func       <= 1'b0;
      req_reg_addr   <= '0;
      req_write_data <= '0;
      req_sda_in     <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a write on the reset address and wait limit, short phases
      write_csr(CSR_TICKS_PER_PHASE, 16'd1);
      csr_valid <= 1'b0;
      run_transfer(FUNC_WRITE, 8'h5A, 8'hA5, RESP_LATE, 3, 8'h00, 0, spent);

      // Zero phase length, top address, no acknowledge wait
      configure(7'h7F, 16'd0, 16'd0);
      // missing target: NACK flag set
      run_transfer(FUNC_WRITE, 8'h00, 8'hFF, RESP_ABSENT, 0, 8'h00, 0, spent);
      // command held high all through a read: ignored while busy, and the
      // new start clears the NACK flag
      run_transfer(FUNC_READ, 8'hFF, 8'h00, RESP_PROMPT, 0, 8'hFF, 100, spent);
      idle_noise(3);

      // Acknowledge on the last allowed sample, then one sample too late
      configure(7'h00, 16'd1, 16'd3);
      run_transfer(FUNC_WRITE, 8'h81, 8'h7E, RESP_LATE, 3, 8'h00, 0, spent);
      run_transfer(FUNC_WRITE, 8'h42, 8'hBD, RESP_LATE, 4, 8'h00, 0, spent);

      // Longest phase and wait: only idle ticks while it is set
      configure(7'h55, 16'hFFFF, 16'hFFFF);
      idle_noise(5);

      // Random sessions, cycling through the idling patterns
      for (int s = 0; s < SESSIONS; s++) begin
         case ($urandom_range(3))
            0: addr = 7'h00;
            1: addr = 7'h7F;
            default: addr = 7'($urandom_range(127));
         endcase
         case ($urandom_range(3))
            0: ticks = 16'd0;
            1, 2: ticks = 16'd1;
            default: ticks = 16'd2;
         endcase
         case ($urandom_range(3))
            0: limit = 16'd0;
            1: limit = 16'hFFFF;
            2: limit = 16'($urandom_range(6));
            default: limit = 16'($urandom_range(40));
         endcase
         configure(addr, ticks, limit);

         case (s % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 82;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 82;
            end
            default: begin
               sender_idle_pct    = 33;
               receiver_stall_pct = 33;
            end
         endcase
         // first session: block the receiver while ticks keep coming
         if (s == 0) hold_armed = 1'b1;

         budget = 0;
         while (budget < SESSION_TICKS) begin
            if ($urandom_range(3) == 0) idle_noise($urandom_range(1, 3));
            run_transfer(1'($urandom_range(1)), pick_byte(), pick_byte(),
                         pick_responder(), $urandom_range(1, 8), pick_byte(),
                         $urandom_range(1) ? 12 : 0, spent);
            budget += spent;
         end
      end

      // Let everything drain, then report
      wait_drained();
      if (mirror.mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/i2cram_pkg.sv
hdl/i2cram_front.sv
hdl/i2cram_seq.sv
hdl/i2c_register_access_master.sv
hdl/i2cram_checker.sv
dv/tb_top.sv
